FILE: src/bdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// types, codes and sizes shared by the bounded deque and its checker
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DEPTH     = 32;
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned PRI_BITS  = 8;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 2;
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(20);
  localparam logic [APB_AW-1:0] CAPACITY_LIMIT_ADDR = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_POP_PRIO   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [PRI_BITS-1:0] pri;
  } entry_t;

endpackage
`default_nettype wire

FILE: src/bounded_deque_priority_end_pop.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_priority_end_pop
// bounded double-ended queue of tag/priority entries held in a ring memory
// ----------------------------------------------------------------------------
// When a request is accepted both end entries are read from the ring memory
// into registers (synchronous read); in the execute state the request is
// resolved: a push writes its entry back, the front pointer and count are
// updated and the result is loaded into the output register. A new request is
// accepted once the execute state is done, even while the result still
// waits; the execute state holds while an earlier result is still stalled.
// The capacity limit is written over APB at address 0; the user must write
// it only while the block is idle, which the block itself does not enforce.
// A value above the depth acts as the depth, and zero refuses every push.
module bounded_deque_priority_end_pop
  import bdq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [TAG_BITS-1:0] entry_tag_i,
  input  wire logic [PRI_BITS-1:0] entry_priority_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [STATUS_W-1:0] status_o,
  output      logic [TAG_BITS-1:0] removed_tag_o,
  output      logic [PRI_BITS-1:0] removed_priority_o,
  output      logic                taken_from_back_o,
  output      logic [CNT_W-1:0]    fill_count_o,
  output      logic                now_empty_o,
  output      logic                now_full_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output      logic [APB_DW-1:0]   prdata,
  output      logic                pready
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;

  entry_t mem_q [DEPTH];
  entry_t rd_front_q, rd_back_q;

  logic [ADDR_W-1:0]   front_q, front_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    limit_q;
  logic [MODE_W-1:0]   req_mode_q;
  entry_t              req_entry_q;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  entry_t              removed_q, removed_d;
  logic                from_back_q, from_back_d;
  logic [CNT_W-1:0]    fill_q;
  logic                empty_q, full_q;

  logic              in_accept;
  logic              proceed;
  logic [CNT_W-1:0]  eff_limit;
  logic              is_full, is_empty;
  logic [ADDR_W-1:0] back_addr, push_back_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              take_back;

  assign in_accept      = in_valid_i && !in_stall_o;
  assign in_stall_o     = (state_q != S_IDLE);
  assign proceed        = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign eff_limit      = (limit_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : limit_q;
  assign is_full        = (count_q >= eff_limit);
  assign is_empty       = (count_q == '0);
  assign back_addr      = front_q + count_q[ADDR_W-1:0] - ADDR_W'(1);
  assign push_back_addr = front_q + count_q[ADDR_W-1:0];

  // apb register
  assign pready = 1'b1;
  assign prdata = APB_DW'(limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == CAPACITY_LIMIT_ADDR)) begin
      limit_q <= pwdata[CNT_W-1:0];
    end
  end

  // request resolution
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = STATUS_DONE;
    removed_d   = '0;
    from_back_d = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = push_back_addr;
    take_back   = 1'b0;

    case (req_mode_q)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (is_full) begin
          status_d = STATUS_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
          if (req_mode_q == MODE_PUSH_FRONT) begin
            front_d = front_q - ADDR_W'(1);
            wr_addr = front_q - ADDR_W'(1);
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_POP_PRIO: begin
        if (is_empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          if (req_mode_q == MODE_POP_BACK) begin
            take_back = 1'b1;
          end else if (req_mode_q == MODE_POP_PRIO && count_q != CNT_W'(1)) begin
            take_back = (rd_front_q.pri < rd_back_q.pri);
          end
          removed_d   = take_back ? rd_back_q : rd_front_q;
          from_back_d = take_back;
          count_d     = count_q - CNT_W'(1);
          if (!take_back) begin
            front_d = front_q + ADDR_W'(1);
          end
        end
      end
      default: begin
      end
    endcase

    if (state_q == S_IDLE) begin
      if (in_accept) begin
        state_d = S_EXEC;
      end
    end else if (proceed) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
    end

    if (!proceed) begin
      wr_en   = 1'b0;
      front_d = front_q;
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      req_mode_q  <= '0;
      req_entry_q <= '0;
      status_q    <= STATUS_DONE;
      removed_q   <= '0;
      from_back_q <= 1'b0;
      fill_q      <= '0;
      empty_q     <= 1'b1;
      full_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        req_mode_q      <= mode_i;
        req_entry_q.tag <= entry_tag_i;
        req_entry_q.pri <= entry_priority_i;
      end
      if (proceed) begin
        status_q    <= status_d;
        removed_q   <= removed_d;
        from_back_q <= from_back_d;
        fill_q      <= count_d;
        empty_q     <= (count_d == '0);
        full_q      <= (count_d >= eff_limit);
      end
    end
  end

  // ring memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= req_entry_q;
    end
    if (in_accept) begin
      rd_front_q <= mem_q[front_q];
      rd_back_q  <= mem_q[back_addr];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign removed_tag_o      = removed_q.tag;
  assign removed_priority_o = removed_q.pri;
  assign taken_from_back_o  = from_back_q;
  assign fill_count_o       = fill_q;
  assign now_empty_o        = empty_q;
  assign now_full_o         = full_q;

endmodule
`default_nettype wire

FILE: src/bdq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks for the bounded deque, bound to its top level
// ----------------------------------------------------------------------------
module bdq_checker
  import bdq_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic [TAG_BITS-1:0] removed_tag_o,
  input wire logic [PRI_BITS-1:0] removed_priority_o,
  input wire logic                taken_from_back_o,
  input wire logic [CNT_W-1:0]    fill_count_o,
  input wire logic                now_empty_o
);

  // a result waiting on a stall stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while busy");

  // refused requests remove nothing
  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_DONE |->
      removed_tag_o == '0 && removed_priority_o == '0 && !taken_from_back_o)
    else $error("refused request reports a removed entry");

  // empty flag matches the fill count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (now_empty_o == (fill_count_o == '0)))
    else $error("empty flag disagrees with fill count");

  // fill count never above the depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_count_o <= CNT_W'(DEPTH))
    else $error("fill count above depth");

endmodule

bind bounded_deque_priority_end_pop bdq_checker u_bdq_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .status_o           (status_o),
  .removed_tag_o      (removed_tag_o),
  .removed_priority_o (removed_priority_o),
  .taken_from_back_o  (taken_from_back_o),
  .fill_count_o       (fill_count_o),
  .now_empty_o        (now_empty_o)
);
`default_nettype wire

FILE: dv/bounded_deque_priority_end_pop_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_deque_priority_end_pop_tb
// self-checking bench for the bounded tag/priority deque
// ----------------------------------------------------------------------------
// Requests go in through the valid/stall input channel, and each accepted
// transaction runs through a behavioral copy of the deque kept in the bench.
// The expected result is queued, and every result leaving the block is
// compared field by field with the oldest one. The capacity limit is
// rewritten over APB between phases, covering zero, one, the depth and a
// value above the depth, and each write is read back. Both channels idle at
// random, except for one long burst without gaps.
// ----------------------------------------------------------------------------
module bounded_deque_priority_end_pop_tb;
  import bdq_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned UNUSED_MODE_FIRST = int'(MODE_POP_PRIO) + 1;
  localparam int unsigned UNUSED_MODE_LAST = (1 << MODE_W) - 1;

  typedef struct packed {
    status_e             status;
    logic [TAG_BITS-1:0] tag;
    logic [PRI_BITS-1:0] pri;
    logic                from_back;
    logic [CNT_W-1:0]    fill;
    logic                empty;
    logic                full;
  } deque_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i;
  logic [TAG_BITS-1:0] entry_tag_i;
  logic [PRI_BITS-1:0] entry_priority_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [TAG_BITS-1:0] removed_tag_o;
  logic [PRI_BITS-1:0] removed_priority_o;
  logic                taken_from_back_o;
  logic [CNT_W-1:0]    fill_count_o;
  logic                now_empty_o;
  logic                now_full_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  entry_t            ring_copy [DEPTH];
  logic [ADDR_W-1:0] ring_front;
  int unsigned       ring_held;
  logic [CNT_W-1:0]  limit_copy;

  deque_result_t pending_results [$];
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;
  bit            idling_on;

  bounded_deque_priority_end_pop i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .entry_tag_i        (entry_tag_i),
    .entry_priority_i   (entry_priority_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .removed_tag_o      (removed_tag_o),
    .removed_priority_o (removed_priority_o),
    .taken_from_back_o  (taken_from_back_o),
    .fill_count_o       (fill_count_o),
    .now_empty_o        (now_empty_o),
    .now_full_o         (now_full_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // deque behavior, applied once per accepted transaction
  function automatic deque_result_t resolve_request(input logic [MODE_W-1:0] mode,
                                                    input logic [TAG_BITS-1:0] tag,
                                                    input logic [PRI_BITS-1:0] pri);
    deque_result_t     res;
    logic [ADDR_W-1:0] back_idx;
    logic              take_back;
    int unsigned       cap;
    res = '0;
    cap = (limit_copy > DEPTH) ? DEPTH : 32'(limit_copy);
    back_idx = ring_front + ADDR_W'(ring_held - 1);
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (ring_held >= cap) begin
          res.status = STATUS_FULL;
        end else begin
          if (mode == MODE_PUSH_FRONT) begin
            ring_front = ring_front - ADDR_W'(1);
            ring_copy[ring_front] = '{tag: tag, pri: pri};
          end else begin
            ring_copy[ring_front + ADDR_W'(ring_held)] = '{tag: tag, pri: pri};
          end
          ring_held++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_POP_PRIO: begin
        if (ring_held == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          if (mode == MODE_POP_FRONT) take_back = 1'b0;
          else if (mode == MODE_POP_BACK) take_back = 1'b1;
          else if (ring_held == 1) take_back = 1'b0;
          else take_back = ring_copy[ring_front].pri < ring_copy[back_idx].pri;
          if (take_back) begin
            res.tag = ring_copy[back_idx].tag;
            res.pri = ring_copy[back_idx].pri;
            res.from_back = 1'b1;
          end else begin
            res.tag = ring_copy[ring_front].tag;
            res.pri = ring_copy[ring_front].pri;
            ring_front = ring_front + ADDR_W'(1);
          end
          ring_held--;
        end
      end
      default: ;
    endcase
    res.fill = CNT_W'(ring_held);
    res.empty = (ring_held == 0);
    res.full = (ring_held >= cap);
    return res;
  endfunction

  function automatic void note_field(input string field, input logic [31:0] exp_val,
                                     input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, exp_val,
                 act_val);
    end
  endfunction

  task automatic check_result();
    deque_result_t exp_res;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: result transaction with nothing expected", $realtime);
    end else begin
      exp_res = pending_results.pop_front();
      note_field("status", 32'(exp_res.status), 32'(status_o));
      note_field("removed_tag", 32'(exp_res.tag), 32'(removed_tag_o));
      note_field("removed_priority", 32'(exp_res.pri), 32'(removed_priority_o));
      note_field("taken_from_back", 32'(exp_res.from_back), 32'(taken_from_back_o));
      note_field("fill_count", 32'(exp_res.fill), 32'(fill_count_o));
      note_field("now_empty", 32'(exp_res.empty), 32'(now_empty_o));
      note_field("now_full", 32'(exp_res.full), 32'(now_full_o));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    out_stall_i <= idling_on && ($urandom_range(99) < 11);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bounded_deque_priority_end_pop test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drives one request and leaves valid high after it is taken
  task automatic issue_request(input logic [MODE_W-1:0] mode, input logic [TAG_BITS-1:0] tag,
                               input logic [PRI_BITS-1:0] pri);
    while (idling_on && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    entry_tag_i <= tag;
    entry_priority_i <= pri;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(resolve_request(mode, tag, pri));
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic read_capacity_limit(input logic [CNT_W-1:0] exp_val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAPACITY_LIMIT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    note_field("capacity_limit readback", APB_DW'(exp_val), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_capacity_limit(input logic [CNT_W-1:0] value);
    wait_quiet();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_LIMIT_ADDR;
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    limit_copy = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    read_capacity_limit(value);
  endtask

  // random requests; push_pct steers the fill level up or down
  task automatic run_traffic(input int unsigned count, input int unsigned push_pct);
    int unsigned       pick;
    logic [MODE_W-1:0] mode;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) mode = MODE_W'($urandom_range(UNUSED_MODE_LAST, UNUSED_MODE_FIRST));
      else if (pick < 3 + push_pct) mode = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      else if ($urandom_range(99) < 40) mode = MODE_POP_PRIO;
      else mode = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
      issue_request(mode, TAG_BITS'($urandom), PRI_BITS'($urandom));
    end
  endtask

  task automatic test_directed_cases();
    read_capacity_limit(LIMIT_RESET);
    issue_request(MODE_POP_FRONT, '1, '1);
    issue_request(MODE_POP_BACK, '0, '0);
    issue_request(MODE_POP_PRIO, '1, '0);
    for (int unsigned m = UNUSED_MODE_FIRST; m <= UNUSED_MODE_LAST; m++)
      issue_request(MODE_W'(m), TAG_BITS'($urandom), PRI_BITS'($urandom));
    issue_request(MODE_PUSH_FRONT, '1, '1);
    issue_request(MODE_PUSH_BACK, '0, '0);
    issue_request(MODE_POP_PRIO, '0, '0);
    issue_request(MODE_PUSH_BACK, 16'h1234, '1);
    issue_request(MODE_POP_PRIO, '0, '0);
    // equal priorities at both ends
    issue_request(MODE_PUSH_BACK, 16'h5555, '0);
    issue_request(MODE_POP_PRIO, '0, '0);
    // single entry left
    issue_request(MODE_POP_PRIO, '1, '1);
    issue_request(MODE_PUSH_FRONT, 16'haaaa, 8'h80);
    issue_request(MODE_PUSH_FRONT, 16'h00ff, 8'h7f);
    issue_request(MODE_PUSH_BACK, 16'hff00, 8'h01);
    issue_request(MODE_POP_BACK, '0, '0);
    issue_request(MODE_POP_FRONT, '0, '0);
    issue_request(MODE_POP_PRIO, '0, '0);
    issue_request(MODE_POP_PRIO, '0, '0);
  endtask

  task automatic test_limit_extremes();
    write_capacity_limit(CNT_W'(1));
    run_traffic(60, 50);
    write_capacity_limit('0);
    run_traffic(30, 60);
    write_capacity_limit('1);
    run_traffic(120, 75);
    write_capacity_limit(CNT_W'(DEPTH));
    run_traffic(80, 25);
  endtask

  task automatic test_random_traffic();
    int unsigned push_mix [5] = '{70, 30, 50, 65, 40};
    for (int unsigned p = 0; p < 5; p++) begin
      write_capacity_limit(CNT_W'($urandom_range(DEPTH, 1)));
      idling_on <= (p != 2);
      run_traffic(200, push_mix[p]);
    end
    idling_on <= 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = '0;
    entry_tag_i = '0;
    entry_priority_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ring_front = '0;
    ring_held = 0;
    limit_copy = LIMIT_RESET;
    mismatch_count = 0;
    quiet_cycles = 0;
    idling_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_limit_extremes();
    test_random_traffic();
    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("bounded_deque_priority_end_pop test passed");
    end else begin
      $display("bounded_deque_priority_end_pop test failed");
    end
    $finish;
  end

endmodule
